// ----- rtl/int4_group_scaled_gemv_row_assert.svh -----
// assertion macros for the int4 group-scaled gemv row block
// the property macros sample on clk and are disabled while rst_n is low
`ifndef INT4_GROUP_SCALED_GEMV_ROW_ASSERT_SVH
`define INT4_GROUP_SCALED_GEMV_ROW_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IGSGEMV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("igsgemv assertion failed");

// next-cycle implication
`define IGSGEMV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("igsgemv assertion failed");

`else

`define IGSGEMV_ASSERT_IMP(lbl, ante, cons)
`define IGSGEMV_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/igsgemv_pkg.sv -----
`default_nettype none

package igsgemv_pkg;

    // column limit and derived widths
    localparam int MAX_COLUMNS = 4096;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int CFG_W       = 13;

    // field widths
    localparam int CODE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int X_W     = 16;
    localparam int SCALE_W = 16;
    localparam int QX_W    = NIB_W + X_W;
    localparam int GACC_W  = 32;
    localparam int RACC_W  = 48;
    localparam int PROD_W  = GACC_W + SCALE_W;
    localparam int FRAC_SH = 12;
    localparam int CONTRIB_W = PROD_W - FRAC_SH;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_COLUMN_COUNT = 1'b0,
        REG_GROUP_LENGTH = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] COLUMN_COUNT_RST = CFG_W'(64);
    localparam logic [CFG_W-1:0] GROUP_LENGTH_RST = CFG_W'(32);

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic row_add;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic group_end;
        logic row_end_pend;
        logic out_blocked;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/igsgemv_ctrl.sv -----
`default_nettype none

module igsgemv_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire igsgemv_pkg::dp_status_t status,
    output igsgemv_pkg::dp_cmd_t         cmd
);
    import igsgemv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD
    } state_t;

    state_t state_reg;
    state_t state_next;

    // commands follow the state
    always_comb
    begin
        in_stall    = (state_reg != S_IDLE);
        cmd.accept  = (state_reg == S_IDLE) && in_valid;
        cmd.mul     = (state_reg == S_MUL);
        cmd.row_add = (state_reg == S_ADD) && !(status.row_end_pend && status.out_blocked);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept && status.group_end)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (cmd.row_add)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/igsgemv_dp.sv -----
`default_nettype none

module igsgemv_dp (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire igsgemv_pkg::dp_cmd_t                      cmd,
    output igsgemv_pkg::dp_status_t                        status,
    input  wire logic                                      cfg_we,
    input  wire logic                                      cfg_index,
    input  wire logic [igsgemv_pkg::CFG_W-1:0]             cfg_data,
    input  wire logic [igsgemv_pkg::CODE_W-1:0]            code_byte,
    input  wire logic signed [igsgemv_pkg::X_W-1:0]        x_value,
    input  wire logic signed [igsgemv_pkg::SCALE_W-1:0]    group_scale,
    output logic                                           out_valid,
    input  wire logic                                      out_stall,
    output logic signed [igsgemv_pkg::RACC_W-1:0]          row_result,
    output logic                                           saturated
);
    import igsgemv_pkg::*;

    logic [CFG_W-1:0]          col_cnt_reg;
    logic [CFG_W-1:0]          grp_len_reg;
    logic [COL_W-1:0]          col_idx_reg;
    logic [COL_W-1:0]          col_idx_next;
    logic [COL_W-1:0]          grp_pos_reg;
    logic [COL_W-1:0]          grp_pos_next;
    logic signed [GACC_W-1:0]  gacc_reg;
    logic signed [GACC_W-1:0]  gacc_next;
    logic signed [RACC_W-1:0]  racc_reg;
    logic signed [RACC_W-1:0]  racc_next;
    logic                      clip_reg;
    logic                      clip_next;
    logic                      row_end_reg;
    logic signed [SCALE_W-1:0] scale_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [RACC_W-1:0]  result_reg;
    logic                      sat_reg;

    logic [CFG_W-1:0]          cols_eff;
    logic [CFG_W-1:0]          glen_eff;
    logic                      row_end;
    logic                      group_end;
    logic [NIB_W-1:0]          nib;
    logic signed [NIB_W-1:0]   q;
    logic signed [QX_W-1:0]    qx;
    logic signed [GACC_W:0]    gsum;
    logic signed [GACC_W-1:0]  gsum_sat;
    logic                      gclip;
    logic signed [CONTRIB_W-1:0] contrib;
    logic signed [RACC_W:0]    rsum;
    logic signed [RACC_W-1:0]  rsum_sat;
    logic                      rclip;

    // effective limits
    always_comb
    begin
        cols_eff = col_cnt_reg;
        if (col_cnt_reg == '0)
        begin
            cols_eff = CFG_W'(1);
        end
        else if (col_cnt_reg > CFG_W'(MAX_COLUMNS))
        begin
            cols_eff = CFG_W'(MAX_COLUMNS);
        end
        glen_eff = (grp_len_reg == '0) ? CFG_W'(1) : grp_len_reg;
    end

    assign row_end   = (CFG_W'(col_idx_reg) + CFG_W'(1)) >= cols_eff;
    assign group_end = row_end || ((CFG_W'(grp_pos_reg) + CFG_W'(1)) >= glen_eff);

    // nibble select and group sum with 32-bit clipping
    assign nib  = col_idx_reg[0] ? code_byte[7:4] : code_byte[3:0];
    assign q    = signed'(nib);
    assign qx   = q * x_value;
    assign gsum = (GACC_W+1)'(gacc_reg) + (GACC_W+1)'(qx);

    always_comb
    begin
        gclip    = (gsum[GACC_W] != gsum[GACC_W-1]);
        gsum_sat = gsum[GACC_W-1:0];
        if (gclip)
        begin
            gsum_sat = gsum[GACC_W] ? {1'b1, {(GACC_W-1){1'b0}}} : {1'b0, {(GACC_W-1){1'b1}}};
        end
    end

    // scaled group sum, floor shift, row sum with 48-bit clipping
    assign contrib = prod_reg[PROD_W-1:FRAC_SH];
    assign rsum    = (RACC_W+1)'(racc_reg) + (RACC_W+1)'(contrib);

    always_comb
    begin
        rclip    = (rsum[RACC_W] != rsum[RACC_W-1]);
        rsum_sat = rsum[RACC_W-1:0];
        if (rclip)
        begin
            rsum_sat = rsum[RACC_W] ? {1'b1, {(RACC_W-1){1'b0}}} : {1'b0, {(RACC_W-1){1'b1}}};
        end
    end

    // next values of the row state
    always_comb
    begin
        col_idx_next   = col_idx_reg;
        grp_pos_next   = grp_pos_reg;
        gacc_next      = gacc_reg;
        racc_next      = racc_reg;
        clip_next      = clip_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.accept)
        begin
            gacc_next    = gsum_sat;
            clip_next    = clip_reg || gclip;
            grp_pos_next = group_end ? '0 : grp_pos_reg + COL_W'(1);
            col_idx_next = row_end ? '0 : col_idx_reg + COL_W'(1);
        end
        if (cmd.row_add)
        begin
            gacc_next = '0;
            if (row_end_reg)
            begin
                racc_next      = '0;
                clip_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            else
            begin
                racc_next = rsum_sat;
                clip_next = clip_reg || rclip;
            end
        end
    end

    // control and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg   <= COLUMN_COUNT_RST;
            grp_len_reg   <= GROUP_LENGTH_RST;
            col_idx_reg   <= '0;
            grp_pos_reg   <= '0;
            gacc_reg      <= '0;
            racc_reg      <= '0;
            clip_reg      <= 1'b0;
            row_end_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_COLUMN_COUNT: col_cnt_reg <= cfg_data;
                    REG_GROUP_LENGTH: grp_len_reg <= cfg_data;
                    default:          col_cnt_reg <= col_cnt_reg;
                endcase
            end
            col_idx_reg   <= col_idx_next;
            grp_pos_reg   <= grp_pos_next;
            gacc_reg      <= gacc_next;
            racc_reg      <= racc_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
            if (cmd.accept)
            begin
                row_end_reg <= row_end;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            scale_reg <= group_scale;
        end
        if (cmd.mul)
        begin
            prod_reg <= gacc_reg * scale_reg;
        end
        if (cmd.row_add && row_end_reg)
        begin
            result_reg <= rsum_sat;
            sat_reg    <= clip_reg || rclip;
        end
    end

    assign status.group_end    = group_end;
    assign status.row_end_pend = row_end_reg;
    assign status.out_blocked  = out_valid_reg && out_stall;

    assign out_valid  = out_valid_reg;
    assign row_result = result_reg;
    assign saturated  = sat_reg;

endmodule

`default_nettype wire

// ----- rtl/int4_group_scaled_gemv_row.sv -----
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+--------------------------------
// in       | input     | in_valid / in_stall | code_byte, x_value, group_scale
// out      | output    | out_valid/out_stall | row_result, saturated
// cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a beat that does not close a group leaves the block ready again; a group-closing beat
// steps through group sum capture, 32x16 scale multiply and 48-bit row add
// a row-closing beat waits in the row add while the output register is full and stalled
// reset (rst_n low, asynchronous) clears row state and loads column_count 64, group_length 32
// the output register holds one finished row, so the next row streams in while it waits
// cfg_ready is always high; registers take effect on the next beat
`default_nettype none

`include "int4_group_scaled_gemv_row_assert.svh"

module int4_group_scaled_gemv_row (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      in_valid,
    output logic                                           in_stall,
    input  wire logic [igsgemv_pkg::CODE_W-1:0]            code_byte,
    input  wire logic signed [igsgemv_pkg::X_W-1:0]        x_value,
    input  wire logic signed [igsgemv_pkg::SCALE_W-1:0]    group_scale,
    output logic                                           out_valid,
    input  wire logic                                      out_stall,
    output logic signed [igsgemv_pkg::RACC_W-1:0]          row_result,
    output logic                                           saturated,
    input  wire logic                                      cfg_valid,
    output logic                                           cfg_ready,
    input  wire logic                                      cfg_index,
    input  wire logic [igsgemv_pkg::CFG_W-1:0]             cfg_data
);
    import igsgemv_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    // sequencer
    igsgemv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    // accumulators, multiplier and output register
    igsgemv_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .status      (dp_status),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .code_byte   (code_byte),
        .x_value     (x_value),
        .group_scale (group_scale),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_result  (row_result),
        .saturated   (saturated)
    );

    // only one datapath command at a time
    `IGSGEMV_ASSERT_IMP(a_cmd_excl, 1'b1, $onehot0({dp_cmd.accept, dp_cmd.mul, dp_cmd.row_add}))
    // a beat inside a group leaves the block ready again
    `IGSGEMV_ASSERT_NXT(a_inner_ready, dp_cmd.accept && !dp_status.group_end, !in_stall)
    // after the multiply the row add is still pending
    `IGSGEMV_ASSERT_NXT(a_mul_busy, dp_cmd.mul, in_stall)

endmodule

`default_nettype wire
